@@ hw/rtl/tbwb_pkg.sv @@
// ----------------------------------------------------------------------------
// tbwb_pkg: shared types and constants for transformed_box_world_bounds
// Coordinate format, intermediate widths, register indexes, beat payloads
// and the final saturation helper.
// ----------------------------------------------------------------------------
package tbwb_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS     = 16;
  localparam int NUM_AXES      = 3;
  localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
  // three products summed: two guard bits
  localparam int SUM_WIDTH     = PROD_WIDTH + 2;
  localparam int SHR_WIDTH     = SUM_WIDTH - FRAC_BITS;
  // shifted sum plus translation: one more bit
  localparam int WORLD_WIDTH   = SHR_WIDTH + 1;
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [WORLD_WIDTH-1:0] world_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_MIN_X = 0,
    CFG_MIN_Y = 1,
    CFG_MIN_Z = 2,
    CFG_MAX_X = 3,
    CFG_MAX_Y = 4,
    CFG_MAX_Z = 5
  } cfg_idx_e;

  typedef struct packed {
    coord_t m_r0c0;
    coord_t m_r0c1;
    coord_t m_r0c2;
    coord_t m_r1c0;
    coord_t m_r1c1;
    coord_t m_r1c2;
    coord_t m_r2c0;
    coord_t m_r2c1;
    coord_t m_r2c2;
    coord_t trans_x;
    coord_t trans_y;
    coord_t trans_z;
  } mat_t;

  typedef struct packed {
    coord_t world_min_x;
    coord_t world_min_y;
    coord_t world_min_z;
    coord_t world_max_x;
    coord_t world_max_y;
    coord_t world_max_z;
  } bounds_t;

  // clamp to the signed coordinate range
  function automatic coord_t saturate(world_t v);
    logic [WORLD_WIDTH-COORD_WIDTH:0] top;
    coord_t                           res;
    top = v[WORLD_WIDTH-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      res = v[COORD_WIDTH-1:0];
    end else if (v[WORLD_WIDTH-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/tbwb_if.sv @@
// ----------------------------------------------------------------------------
// tbwb_if: valid/ready channels of transformed_box_world_bounds
// One channel carries a world matrix beat, the other a bounds beat.
// ----------------------------------------------------------------------------
interface tbwb_mat_if;
  logic            valid;
  logic            ready;
  tbwb_pkg::mat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbwb_bounds_if;
  logic              valid;
  logic              ready;
  tbwb_pkg::bounds_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/transformed_box_world_bounds.sv @@
// ----------------------------------------------------------------------------
// transformed_box_world_bounds: world bounds of a local box under a matrix
// Transforms the eight corners of a local box and returns per-axis extremes.
// ----------------------------------------------------------------------------
// Usage:
//   Load the local box corners through the write port (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i) while no beat is in flight; indexes 6 and 7 are ignored.
//   Each beat on mat_i is one affine matrix (3x3 plus translation, Q16.16).
//   Each beat on bnd_o is the saturated min/max world coordinate per axis.
//   Since the map is affine and separable, each extreme is the sum of the
//   per-term extremes of local_min*m and local_max*m, so 18 products cover
//   all eight corners.
// Timing:
//   Five register levels: input, products, per-term min/max, column sums,
//   result; an accepted beat passes through each in turn to bnd_o. One
//   beat per cycle sustained while bnd_o does not stall; the 18 parallel
//   32x32 products set that, each registered before the sums.
// Reset clears the box registers to zero and empties the pipeline.
// A stall on bnd_o holds the result and fills the pipeline back to front;
// mat_i.ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module transformed_box_world_bounds (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tbwb_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx_i,
  input  logic [tbwb_pkg::COORD_WIDTH-1:0]       cfg_wdata_i,
  tbwb_mat_if.sink                               mat_i,
  tbwb_bounds_if.source                          bnd_o
);

  localparam int NA = tbwb_pkg::NUM_AXES;

  // local box corners
  tbwb_pkg::coord_t box_min_q [NA];
  tbwb_pkg::coord_t box_max_q [NA];

  // stage valids
  logic v0_q, v1_q, v2_q, v3_q, out_v_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // stage payloads
  tbwb_pkg::coord_t  m_d   [NA][NA];
  tbwb_pkg::coord_t  t_d   [NA];
  tbwb_pkg::coord_t  m_q   [NA][NA];
  tbwb_pkg::coord_t  t0_q  [NA];
  tbwb_pkg::prod_t   plo_d [NA][NA];
  tbwb_pkg::prod_t   phi_d [NA][NA];
  tbwb_pkg::prod_t   plo_q [NA][NA];
  tbwb_pkg::prod_t   phi_q [NA][NA];
  tbwb_pkg::coord_t  t1_q  [NA];
  tbwb_pkg::prod_t   mn_d  [NA][NA];
  tbwb_pkg::prod_t   mx_d  [NA][NA];
  tbwb_pkg::prod_t   mn_q  [NA][NA];
  tbwb_pkg::prod_t   mx_q  [NA][NA];
  tbwb_pkg::coord_t  t2_q  [NA];
  tbwb_pkg::sum_t    smn_d [NA];
  tbwb_pkg::sum_t    smx_d [NA];
  tbwb_pkg::sum_t    smn_q [NA];
  tbwb_pkg::sum_t    smx_q [NA];
  tbwb_pkg::coord_t  t3_q  [NA];
  tbwb_pkg::coord_t  wmn   [NA];
  tbwb_pkg::coord_t  wmx   [NA];
  tbwb_pkg::bounds_t out_d;
  tbwb_pkg::bounds_t out_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (tbwb_pkg::cfg_idx_e'(cfg_idx_i))
        tbwb_pkg::CFG_MIN_X: box_min_q[0] <= cfg_wdata_i;
        tbwb_pkg::CFG_MIN_Y: box_min_q[1] <= cfg_wdata_i;
        tbwb_pkg::CFG_MIN_Z: box_min_q[2] <= cfg_wdata_i;
        tbwb_pkg::CFG_MAX_X: box_max_q[0] <= cfg_wdata_i;
        tbwb_pkg::CFG_MAX_Y: box_max_q[1] <= cfg_wdata_i;
        tbwb_pkg::CFG_MAX_Z: box_max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ flow ctrl
  assign rdy4 = !out_v_q || bnd_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign mat_i.ready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0) v0_q    <= mat_i.valid;
      if (rdy1) v1_q    <= v0_q;
      if (rdy2) v2_q    <= v1_q;
      if (rdy3) v3_q    <= v2_q;
      if (rdy4) out_v_q <= v3_q;
    end
  end

  // ------------------------------------------------------------ datapath
  always_comb begin
    m_d[0][0] = mat_i.data.m_r0c0;
    m_d[0][1] = mat_i.data.m_r0c1;
    m_d[0][2] = mat_i.data.m_r0c2;
    m_d[1][0] = mat_i.data.m_r1c0;
    m_d[1][1] = mat_i.data.m_r1c1;
    m_d[1][2] = mat_i.data.m_r1c2;
    m_d[2][0] = mat_i.data.m_r2c0;
    m_d[2][1] = mat_i.data.m_r2c1;
    m_d[2][2] = mat_i.data.m_r2c2;
    t_d[0]    = mat_i.data.trans_x;
    t_d[1]    = mat_i.data.trans_y;
    t_d[2]    = mat_i.data.trans_z;
  end

  // row r of the matrix scales local coordinate r
  always_comb begin
    for (int r = 0; r < NA; r++) begin
      for (int c = 0; c < NA; c++) begin
        plo_d[r][c] = tbwb_pkg::prod_t'(box_min_q[r]) * tbwb_pkg::prod_t'(m_q[r][c]);
        phi_d[r][c] = tbwb_pkg::prod_t'(box_max_q[r]) * tbwb_pkg::prod_t'(m_q[r][c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      for (int c = 0; c < NA; c++) begin
        if (plo_q[r][c] < phi_q[r][c]) begin
          mn_d[r][c] = plo_q[r][c];
          mx_d[r][c] = phi_q[r][c];
        end else begin
          mn_d[r][c] = phi_q[r][c];
          mx_d[r][c] = plo_q[r][c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NA; c++) begin
      smn_d[c] = tbwb_pkg::sum_t'(mn_q[0][c]) + tbwb_pkg::sum_t'(mn_q[1][c])
               + tbwb_pkg::sum_t'(mn_q[2][c]);
      smx_d[c] = tbwb_pkg::sum_t'(mx_q[0][c]) + tbwb_pkg::sum_t'(mx_q[1][c])
               + tbwb_pkg::sum_t'(mx_q[2][c]);
    end
  end

  // floor shift then translate; both monotone, so extremes carry through
  always_comb begin
    for (int c = 0; c < NA; c++) begin
      wmn[c] = tbwb_pkg::saturate(
          tbwb_pkg::world_t'($signed(smn_q[c][tbwb_pkg::SUM_WIDTH-1:tbwb_pkg::FRAC_BITS]))
        + tbwb_pkg::world_t'(t3_q[c]));
      wmx[c] = tbwb_pkg::saturate(
          tbwb_pkg::world_t'($signed(smx_q[c][tbwb_pkg::SUM_WIDTH-1:tbwb_pkg::FRAC_BITS]))
        + tbwb_pkg::world_t'(t3_q[c]));
    end
    out_d.world_min_x = wmn[0];
    out_d.world_min_y = wmn[1];
    out_d.world_min_z = wmn[2];
    out_d.world_max_x = wmx[0];
    out_d.world_max_y = wmx[1];
    out_d.world_max_z = wmx[2];
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && mat_i.valid) begin
      m_q  <= m_d;
      t0_q <= t_d;
    end
    if (rdy1 && v0_q) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      t1_q  <= t0_q;
    end
    if (rdy2 && v1_q) begin
      mn_q <= mn_d;
      mx_q <= mx_d;
      t2_q <= t1_q;
    end
    if (rdy3 && v2_q) begin
      smn_q <= smn_d;
      smx_q <= smx_d;
      t3_q  <= t2_q;
    end
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign bnd_o.valid = out_v_q;
  assign bnd_o.data  = out_q;

  // ------------------------------------------------------------ assertions
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.world_min_x <= out_q.world_max_x)
             && (out_q.world_min_y <= out_q.world_max_y)
             && (out_q.world_min_z <= out_q.world_max_z))
    else $error("world min above max");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v0_q && !v1_q && !v2_q && !v3_q && !out_v_q) |-> mat_i.ready)
    else $error("empty pipeline refuses a beat");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(v3_q))
    else $error("result beat without a source beat");

endmodule

@@ dv/transformed_box_world_bounds_checker.sv @@
// ----------------------------------------------------------------------------
// transformed_box_world_bounds_checker: bounds predictor and scoreboard
// Tracks the local box from register writes, predicts the world bounds of
// every accepted matrix beat and compares each bounds beat, in order, with
// the oldest prediction. Counts mismatches and beats still in flight.
// ----------------------------------------------------------------------------
module transformed_box_world_bounds_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tbwb_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [tbwb_pkg::COORD_WIDTH-1:0]   cfg_wdata_i,
  tbwb_mat_if                                mat_i,
  tbwb_bounds_if                             bnd_i,
  output int                                 mismatch_count_o,
  output int                                 pending_o
);

  localparam int     CW         = tbwb_pkg::COORD_WIDTH;
  localparam int     NUM_FIELDS = 6;
  localparam int     WIDE_WIDTH = 3 * CW;
  localparam tbwb_pkg::coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam tbwb_pkg::coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [WIDE_WIDTH-1:0] wide_t;

  tbwb_pkg::coord_t  box_q [NUM_FIELDS];
  tbwb_pkg::bounds_t bounds_q [$];
  int                mismatches;
  int                in_flight;

  string field_name [NUM_FIELDS] = '{"world_min_x", "world_min_y", "world_min_z",
                                     "world_max_x", "world_max_y", "world_max_z"};

  assign mismatch_count_o = mismatches;
  assign pending_o        = in_flight;

  // Walks all eight corners; each coordinate is an exact sum, floored once,
  // offset by the translation and clamped before the extremes are taken.
  function automatic tbwb_pkg::bounds_t world_bounds(tbwb_pkg::mat_t m);
    tbwb_pkg::coord_t lin [3][3];
    tbwb_pkg::coord_t trn [3];
    tbwb_pkg::coord_t corner [3];
    tbwb_pkg::coord_t lo [3];
    tbwb_pkg::coord_t hi [3];
    tbwb_pkg::coord_t w;
    wide_t            acc;
    wide_t            lhs;
    wide_t            rhs;
    lin[0] = '{m.m_r0c0, m.m_r0c1, m.m_r0c2};
    lin[1] = '{m.m_r1c0, m.m_r1c1, m.m_r1c2};
    lin[2] = '{m.m_r2c0, m.m_r2c1, m.m_r2c2};
    trn    = '{m.trans_x, m.trans_y, m.trans_z};
    for (int k = 0; k < 8; k++) begin
      corner[0] = k[0] ? box_q[tbwb_pkg::CFG_MAX_X] : box_q[tbwb_pkg::CFG_MIN_X];
      corner[1] = k[1] ? box_q[tbwb_pkg::CFG_MAX_Y] : box_q[tbwb_pkg::CFG_MIN_Y];
      corner[2] = k[2] ? box_q[tbwb_pkg::CFG_MAX_Z] : box_q[tbwb_pkg::CFG_MIN_Z];
      for (int c = 0; c < tbwb_pkg::NUM_AXES; c++) begin
        acc = '0;
        for (int r = 0; r < 3; r++) begin
          lhs = corner[r];
          rhs = lin[r][c];
          acc = acc + lhs * rhs;
        end
        rhs = trn[c];
        acc = (acc >>> tbwb_pkg::FRAC_BITS) + rhs;
        if (acc > COORD_MAX) begin
          w = COORD_MAX;
        end else if (acc < COORD_MIN) begin
          w = COORD_MIN;
        end else begin
          w = acc[CW-1:0];
        end
        if (k == 0 || w < lo[c]) lo[c] = w;
        if (k == 0 || w > hi[c]) hi[c] = w;
      end
    end
    return tbwb_pkg::bounds_t'{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tbwb_pkg::bounds_t want;
    tbwb_pkg::coord_t  e;
    tbwb_pkg::coord_t  a;
    if (!rst_ni) begin
      bounds_q.delete();
      foreach (box_q[i]) box_q[i] = '0;
      mismatches = 0;
      in_flight  = 0;
    end else begin
      if (bnd_i.valid && bnd_i.ready) begin
        if (bounds_q.size() == 0) begin
          $error("bounds beat with no matrix beat outstanding");
          mismatches++;
        end else begin
          want = bounds_q.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            e = want[(NUM_FIELDS-1-f)*CW +: CW];
            a = bnd_i.data[(NUM_FIELDS-1-f)*CW +: CW];
            if (e !== a) begin
              $error("%s: expected %0d, actual %0d", field_name[f], e, a);
              mismatches++;
            end
          end
        end
      end
      if (mat_i.valid && mat_i.ready) bounds_q.push_back(world_bounds(mat_i.data));
      // indexes past the last box register are dropped
      if (cfg_we_i && cfg_idx_i <= tbwb_pkg::CFG_MAX_Z) box_q[cfg_idx_i] = cfg_wdata_i;
      in_flight = bounds_q.size();
    end
  end

endmodule

@@ dv/transformed_box_world_bounds_tb.sv @@
// ----------------------------------------------------------------------------
// transformed_box_world_bounds_tb: testbench top
// Loads a series of local boxes (normal, inverted, full-range) and streams
// directed and random world matrices with random gaps and output stalls;
// the checker predicts and compares every bounds beat.
// ----------------------------------------------------------------------------
module transformed_box_world_bounds_tb;

  localparam int          CW             = tbwb_pkg::COORD_WIDTH;
  localparam int          IW             = tbwb_pkg::CFG_IDX_WIDTH;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_ITEMS    = 100;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int unsigned LIN_SPAN       = 1 << 18;
  localparam int unsigned TRN_SPAN       = 1 << 26;
  localparam int unsigned BOX_SPAN       = 1 << 20;
  localparam tbwb_pkg::coord_t Q_ONE     = 32'sh0001_0000;
  localparam tbwb_pkg::coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam tbwb_pkg::coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [IW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IW-1:0] IDX_SPARE_HI = 3'd7;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [IW-1:0] cfg_idx_i;
  logic [CW-1:0] cfg_wdata_i;

  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatches;
  int pending;

  tbwb_mat_if    mat_if ();
  tbwb_bounds_if bnd_if ();

  always #1 clk_i = ~clk_i;

  transformed_box_world_bounds uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_i       (mat_if),
    .bnd_o       (bnd_if)
  );

  transformed_box_world_bounds_checker bounds_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mat_i            (mat_if),
    .bnd_i            (bnd_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // output stalls: random bursts with bnd_if.ready held low
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      bnd_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      bnd_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((mat_if.valid && mat_if.ready) || (bnd_if.valid && bnd_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic tbwb_pkg::coord_t rand_coord(int unsigned span);
    tbwb_pkg::coord_t v;
    case ($urandom_range(0, 15))
      0:       v = COORD_MAX;
      1:       v = COORD_MIN;
      2:       v = '0;
      3:       v = '1;
      4, 5, 6: v = $urandom;
      default: v = tbwb_pkg::coord_t'($urandom_range(0, 2 * span)) - tbwb_pkg::coord_t'(span);
    endcase
    return v;
  endfunction

  // translation sits in the three low slices
  function automatic tbwb_pkg::mat_t rand_matrix();
    logic [$bits(tbwb_pkg::mat_t)-1:0] raw;
    for (int i = 0; i < 12; i++) begin
      raw[i*CW +: CW] = rand_coord(i < tbwb_pkg::NUM_AXES ? TRN_SPAN : LIN_SPAN);
    end
    return tbwb_pkg::mat_t'(raw);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_matrix(input tbwb_pkg::mat_t m);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      mat_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mat_if.valid <= 1'b1;
    mat_if.data  <= m;
    do @(posedge clk_i); while (!mat_if.ready);
    @(negedge clk_i);
  endtask

  // box registers change only with the pipeline drained
  task automatic load_box(input tbwb_pkg::coord_t v [6]);
    mat_if.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= tbwb_pkg::cfg_idx_e'(i);
      cfg_wdata_i <= v[i];
      @(negedge clk_i);
    end
    if ($urandom_range(0, 1)) begin
      cfg_idx_i   <= $urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI;
      cfg_wdata_i <= $urandom;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    tbwb_pkg::mat_t   directed [12];
    tbwb_pkg::coord_t box_v [6];
    tbwb_pkg::coord_t swap;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= tbwb_pkg::CFG_MIN_X;
    cfg_wdata_i  <= '0;
    mat_if.valid <= 1'b0;
    mat_if.data  <= '0;

    directed[0]  = tbwb_pkg::mat_t'{Q_ONE, '0, '0, '0, Q_ONE, '0, '0, '0, Q_ONE, '0, '0, '0};
    directed[1]  = tbwb_pkg::mat_t'{default: '0};
    directed[2]  = tbwb_pkg::mat_t'{default: COORD_MAX};
    directed[3]  = tbwb_pkg::mat_t'{default: COORD_MIN};
    directed[4]  = tbwb_pkg::mat_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MIN, COORD_MIN, COORD_MIN};
    directed[5]  = tbwb_pkg::mat_t'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MAX, COORD_MAX, COORD_MAX};
    directed[6]  = tbwb_pkg::mat_t'{-Q_ONE, '0, '0, '0, -Q_ONE, '0, '0, '0, -Q_ONE,
                                    Q_ONE * 5, -(Q_ONE * 3), Q_ONE >>> 1};
    directed[7]  = tbwb_pkg::mat_t'{'0, Q_ONE, '0, -Q_ONE, '0, '0, '0, '0, Q_ONE,
                                    Q_ONE * 10, -(Q_ONE * 4), Q_ONE >>> 3};
    directed[8]  = tbwb_pkg::mat_t'{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                    COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                    COORD_MIN, COORD_MAX, COORD_MIN};
    directed[9]  = tbwb_pkg::mat_t'{default: '1};
    directed[10] = tbwb_pkg::mat_t'{default: tbwb_pkg::coord_t'(1)};
    directed[11] = tbwb_pkg::mat_t'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                    32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                                    32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                    32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // small asymmetric box: every directed matrix
    box_v = '{-Q_ONE, -(Q_ONE * 2), -(Q_ONE >>> 1), Q_ONE, Q_ONE * 3, Q_ONE >>> 2};
    load_box(box_v);
    foreach (directed[i]) send_matrix(directed[i]);

    // full-range box
    box_v = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX};
    load_box(box_v);
    for (int i = 0; i < 6; i++) send_matrix(directed[i]);

    // minimum above maximum on every axis
    box_v = '{Q_ONE * 2, Q_ONE * 5, Q_ONE, -(Q_ONE * 3), -Q_ONE, -(Q_ONE * 7)};
    load_box(box_v);
    for (int i = 0; i < 6; i++) send_matrix(directed[i]);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == RANDOM_PHASES - 1);
      foreach (box_v[i]) begin
        if (p == 1) box_v[i] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        else        box_v[i] = rand_coord(BOX_SPAN);
      end
      if (p == 2) begin
        for (int i = 0; i < 3; i++) begin
          if (box_v[i] < box_v[i+3]) begin
            swap       = box_v[i];
            box_v[i]   = box_v[i+3];
            box_v[i+3] = swap;
          end
        end
      end
      load_box(box_v);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // occasional full drain before the next beat
        if (!calm && $urandom_range(0, 149) == 0) begin
          mat_if.valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk_i);
        end
        send_matrix(rand_matrix());
      end
    end

    mat_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tbwb_pkg.sv
hw/rtl/tbwb_if.sv
hw/rtl/transformed_box_world_bounds.sv
dv/transformed_box_world_bounds_checker.sv
dv/transformed_box_world_bounds_tb.sv
